// File: rtl/vdi_pkg.sv
// vdi_pkg: shared types, constants and the coordinate compare for the vertex dedup indexer
// no dependencies
package vdi_pkg;

   localparam int COORD_W              = 64;
   localparam int INDEX_W              = 10;
   localparam int DEFAULT_MAX_VERTICES = 1024;
   localparam int DEFAULT_NUM_CELLS    = 16;

   typedef struct packed {
      logic [COORD_W-1:0] x_bits;
      logic [COORD_W-1:0] y_bits;
      logic [COORD_W-1:0] z_bits;
      logic               new_mesh;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] vertex_index;
      logic               is_new;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] x_bits;
      logic [COORD_W-1:0] y_bits;
      logic [COORD_W-1:0] z_bits;
   } coord_type;

   // equal bit patterns, or both zeros of either sign
   function automatic logic coord_match(input logic [COORD_W-1:0] a,
                                        input logic [COORD_W-1:0] b);
      return (a == b) || ((a[COORD_W-2:0] == '0) && (b[COORD_W-2:0] == '0));
   endfunction

   function automatic logic vertex_match(input coord_type a, input coord_type b);
      return coord_match(a.x_bits, b.x_bits) && coord_match(a.y_bits, b.y_bits) &&
             coord_match(a.z_bits, b.z_bits);
   endfunction

endpackage

// File: rtl/vdi_cell.sv
// vdi_cell: one search cell, owns one bank of stored vertices and compares one row per beat
// depends on vdi_pkg
module vdi_cell import vdi_pkg::*; #(
   parameter int CELL_ID = 0,
   parameter int CELL_W  = 4,
   parameter int ROWS    = 64,
   parameter int ROW_W   = 6,
   parameter int IDX_W   = 10,
   parameter int CNT_W   = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  coord_type        query,
   input  logic [CNT_W-1:0] count,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  coord_type        wr_data,
   input  logic             in_valid,
   input  logic [ROW_W-1:0] in_row,
   input  logic             in_hit,
   input  logic [IDX_W-1:0] in_idx,
   output logic             out_valid,
   output logic [ROW_W-1:0] out_row,
   output logic             out_hit,
   output logic [IDX_W-1:0] out_idx
);

   coord_type        entry_ff [ROWS];
   coord_type        rd_ff;
   logic             a_valid_ff;
   logic [ROW_W-1:0] a_row_ff;
   logic             a_hit_ff;
   logic [IDX_W-1:0] a_idx_ff;
   logic             out_valid_ff;
   logic [ROW_W-1:0] out_row_ff;
   logic             out_hit_ff;
   logic [IDX_W-1:0] out_idx_ff;

   logic [IDX_W-1:0] here_idx;
   logic             in_range;
   logic             match;

   // bank write, entry k lives in cell k mod cells at row k / cells
   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx[CELL_W-1:0] == CELL_W'(CELL_ID))) begin
         entry_ff[wr_idx[IDX_W-1:CELL_W]] <= wr_data;
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      rd_ff    <= entry_ff[in_row];
      a_row_ff <= in_row;
      a_hit_ff <= in_hit;
      a_idx_ff <= in_idx;
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
   end

   // compare stage, an earlier hit in the chain wins
   assign here_idx = {a_row_ff, CELL_W'(CELL_ID)};
   assign in_range = (IDX_W+1)'(here_idx) < (IDX_W+1)'(count);
   assign match    = vertex_match(rd_ff, query) && in_range;

   always_ff @(posedge clock) begin
      out_row_ff <= a_row_ff;
      out_hit_ff <= a_hit_ff || match;
      out_idx_ff <= a_hit_ff ? a_idx_ff : here_idx;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= a_valid_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_row   = out_row_ff;
   assign out_hit   = out_hit_ff;
   assign out_idx   = out_idx_ff;

endmodule

// File: rtl/vertex_dedup_indexer_unit.sv
// vertex_dedup_indexer_unit: top level, search sequencer plus a chain of vdi_cell banks
// depends on vdi_pkg and vdi_cell
//
// Takes one vertex per req beat (three double bit patterns and a new-mesh flag) and returns
// one rsp beat with the index of the matching stored vertex, or appends it and flags it as
// new; +0 and -0 compare equal. When the table already holds MAX_VERTICES vertices a new one
// is dropped and the rsp beat carries overflow with index 0. The stored vertices are spread
// over NUM_CELLS cells (entry k in cell k mod NUM_CELLS); a search walks the occupied rows,
// one row entering the head of the chain per cycle, and each row record passes the read and
// compare registers of each cell in turn, picking up the first matching entry. One vertex is
// worked on at a time; an empty table skips the sweep, and the row sweep and the chain
// length set how long a search takes. A finished result may sit in the rsp register while
// the next vertex is already taken. NUM_CELLS must be a power of two, at least 2. Stored
// entries have no reset; a new-mesh beat or reset only clears the count.
module vertex_dedup_indexer_unit import vdi_pkg::*; #(
   parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES,
   parameter int NUM_CELLS    = DEFAULT_NUM_CELLS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CELL_W = $clog2(NUM_CELLS);
   localparam int ROWS   = (MAX_VERTICES + NUM_CELLS - 1) / NUM_CELLS;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDX_W  = ROW_W + CELL_W;
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

   typedef enum logic [1:0] {
      IDLE,
      SWEEP,
      DRAIN,
      DONE
   } state_type;

   state_type        state_ff;
   coord_type        query_ff;
   logic [CNT_W-1:0] count_ff;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] last_row_ff;
   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   // row records travelling down the chain
   logic             ch_valid [NUM_CELLS+1];
   logic [ROW_W-1:0] ch_row   [NUM_CELLS+1];
   logic             ch_hit   [NUM_CELLS+1];
   logic [IDX_W-1:0] ch_idx   [NUM_CELLS+1];

   logic             req_take;
   logic [CNT_W-1:0] start_cnt;
   logic [IDX_W-1:0] start_last;
   logic             can_emit;
   logic             table_full;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;

   assign req_stall  = (state_ff != IDLE);
   assign req_take   = req_valid && !req_stall;
   // a new-mesh beat empties the table before its own lookup
   assign start_cnt  = req_data.new_mesh ? '0 : count_ff;
   assign start_last = IDX_W'(start_cnt - 1'b1);

   assign can_emit   = !rsp_valid_ff || !rsp_stall;
   assign table_full = (count_ff == CNT_W'(MAX_VERTICES));
   assign wr_idx     = IDX_W'(count_ff);
   // append happens in the cycle the result is loaded
   assign wr_en      = (state_ff == DONE) && can_emit && !hit_ff && !table_full;

   // head of the chain: one row per cycle while sweeping
   assign ch_valid[0] = (state_ff == SWEEP);
   assign ch_row[0]   = row_ff;
   assign ch_hit[0]   = 1'b0;
   assign ch_idx[0]   = '0;

   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      vdi_cell #(
         .CELL_ID(c),
         .CELL_W (CELL_W),
         .ROWS   (ROWS),
         .ROW_W  (ROW_W),
         .IDX_W  (IDX_W),
         .CNT_W  (CNT_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .query    (query_ff),
         .count    (count_ff),
         .wr_en    (wr_en),
         .wr_idx   (wr_idx),
         .wr_data  (query_ff),
         .in_valid (ch_valid[c]),
         .in_row   (ch_row[c]),
         .in_hit   (ch_hit[c]),
         .in_idx   (ch_idx[c]),
         .out_valid(ch_valid[c+1]),
         .out_row  (ch_row[c+1]),
         .out_hit  (ch_hit[c+1]),
         .out_idx  (ch_idx[c+1])
      );
   end

   // sequencer: state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         row_ff       <= '0;
         last_row_ff  <= '0;
         hit_ff       <= 1'b0;
         hit_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // rsp register loads when done and drains independently of the search
         if ((state_ff == DONE) && can_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // rows leave the chain in order, so the first hit seen is the lowest index
         if (ch_valid[NUM_CELLS] && ch_hit[NUM_CELLS] && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= ch_idx[NUM_CELLS];
         end
         case (state_ff)
            IDLE: begin
               if (req_take) begin
                  query_ff.x_bits <= req_data.x_bits;
                  query_ff.y_bits <= req_data.y_bits;
                  query_ff.z_bits <= req_data.z_bits;
                  count_ff        <= start_cnt;
                  row_ff          <= '0;
                  last_row_ff     <= start_last[IDX_W-1:CELL_W];
                  hit_ff          <= 1'b0;
                  // empty table needs no sweep
                  state_ff        <= (start_cnt == '0) ? DONE : SWEEP;
               end
            end
            SWEEP: begin
               row_ff <= row_ff + 1'b1;
               if (row_ff == last_row_ff) begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               if (ch_valid[NUM_CELLS] && (ch_row[NUM_CELLS] == last_row_ff)) begin
                  state_ff <= DONE;
               end
            end
            DONE: begin
               if (can_emit) begin
                  if (hit_ff) begin
                     rsp_data_ff.vertex_index <= INDEX_W'(hit_idx_ff);
                     rsp_data_ff.is_new       <= 1'b0;
                     rsp_data_ff.overflow     <= 1'b0;
                  end else if (table_full) begin
                     rsp_data_ff.vertex_index <= '0;
                     rsp_data_ff.is_new       <= 1'b0;
                     rsp_data_ff.overflow     <= 1'b1;
                  end else begin
                     rsp_data_ff.vertex_index <= INDEX_W'(count_ff);
                     rsp_data_ff.is_new       <= 1'b1;
                     rsp_data_ff.overflow     <= 1'b0;
                     count_ff                 <= count_ff + 1'b1;
                  end
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sim/vdi_checker.sv
// vdi_checker: watches the req and rsp channels of the vertex dedup indexer, predicts each index
// and compares it field by field; depends on vdi_pkg
module vdi_checker import vdi_pkg::*; #(
   parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow copy of the vertex table
   logic [COORD_W-1:0] x_seen [MAX_VERTICES];
   logic [COORD_W-1:0] y_seen [MAX_VERTICES];
   logic [COORD_W-1:0] z_seen [MAX_VERTICES];
   int unsigned        seen_count = 0;

   rsp_type pending_indices [$];
   int      errors  = 0;
   int      waiting = 0;

   assign fail_count    = errors;
   assign pending_count = waiting;

   // +0 and -0 are the same point
   function automatic logic same_coord(input logic [COORD_W-1:0] a,
                                       input logic [COORD_W-1:0] b);
      logic a_zero;
      logic b_zero;
      a_zero = ~|a[COORD_W-2:0];
      b_zero = ~|b[COORD_W-2:0];
      return (a == b) || (a_zero && b_zero);
   endfunction

   function automatic rsp_type lookup_vertex(input req_type beat);
      rsp_type     result;
      int unsigned k;
      result = '0;
      if (beat.new_mesh) seen_count = 0;
      for (k = 0; k < seen_count; k++) begin
         if (same_coord(x_seen[k], beat.x_bits) && same_coord(y_seen[k], beat.y_bits) &&
             same_coord(z_seen[k], beat.z_bits)) begin
            result.vertex_index = k[INDEX_W-1:0];
            return result;
         end
      end
      if (seen_count >= MAX_VERTICES) begin
         result.overflow = 1'b1;
         return result;
      end
      x_seen[seen_count]  = beat.x_bits;
      y_seen[seen_count]  = beat.y_bits;
      z_seen[seen_count]  = beat.z_bits;
      result.vertex_index = seen_count[INDEX_W-1:0];
      result.is_new       = 1'b1;
      seen_count++;
      return result;
   endfunction

   task automatic check_field(input string field, input logic [INDEX_W-1:0] want,
                              input logic [INDEX_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         // retire first so a beat never meets its own prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_indices.size() == 0) begin
               $error("unexpected rsp beat: vertex_index %0d is_new %0b overflow %0b",
                      rsp_data.vertex_index, rsp_data.is_new, rsp_data.overflow);
               errors++;
            end else begin
               want = pending_indices.pop_front();
               check_field("vertex_index", want.vertex_index, rsp_data.vertex_index);
               check_field("is_new", INDEX_W'(want.is_new), INDEX_W'(rsp_data.is_new));
               check_field("overflow", INDEX_W'(want.overflow), INDEX_W'(rsp_data.overflow));
            end
         end
         if (req_valid && !req_stall) begin
            want = lookup_vertex(req_data);
            pending_indices.insert(pending_indices.size(), want);
         end
         waiting = pending_indices.size();
      end
   end

endmodule

// File: sim/tb_top.sv
// tb_top: stimulus and verdict for vertex_dedup_indexer_unit
// depends on vdi_pkg, vdi_checker and the unit's rtl
module tb_top import vdi_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_VERTS        = DEFAULT_MAX_VERTICES;
   localparam int NUM_CELLS        = DEFAULT_NUM_CELLS;
   // full table sweep plus the cell chain, with margin
   localparam int DRAIN_CYCLES     = MAX_VERTS / NUM_CELLS + 2 * NUM_CELLS + 16;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int SMALL_MESH_ITEMS = 780;
   localparam int PROBE_ITEMS      = 60;
   localparam int CALM_ITEMS       = 400;

   // interesting double bit patterns
   localparam logic [COORD_W-1:0] POS_ZERO    = 64'h0000_0000_0000_0000;
   localparam logic [COORD_W-1:0] NEG_ZERO    = 64'h8000_0000_0000_0000;
   localparam logic [COORD_W-1:0] POS_ONE     = 64'h3FF0_0000_0000_0000;
   localparam logic [COORD_W-1:0] NEG_ONE     = 64'hBFF0_0000_0000_0000;
   localparam logic [COORD_W-1:0] POS_INF     = 64'h7FF0_0000_0000_0000;
   localparam logic [COORD_W-1:0] NEG_INF     = 64'hFFF0_0000_0000_0000;
   localparam logic [COORD_W-1:0] MAX_FINITE  = 64'h7FEF_FFFF_FFFF_FFFF;
   localparam logic [COORD_W-1:0] MIN_SUBNORM = 64'h0000_0000_0000_0001;
   localparam logic [COORD_W-1:0] NEG_SUBNORM = 64'h8000_0000_0000_0001;
   localparam logic [COORD_W-1:0] QUIET_NAN   = 64'h7FF8_0000_0000_0000;
   localparam logic [COORD_W-1:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // high while both sides must run without idling
   logic    calm      = 1'b0;
   int      fail_count;
   int      pending_count;
   int      cycle_count = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   vertex_dedup_indexer_unit #(
      .MAX_VERTICES(MAX_VERTS),
      .NUM_CELLS   (NUM_CELLS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   vdi_checker #(
      .MAX_VERTICES(MAX_VERTS)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   // receiver back-pressure, stalling about 12 percent of the time outside the calm stretch
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 12);
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic coord_type make_vertex(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y,
                                             input logic [COORD_W-1:0] z);
      coord_type v;
      v.x_bits = x;
      v.y_bits = y;
      v.z_bits = z;
      return v;
   endfunction

   // small pool of common values so partial matches and zero pairs come up often
   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 11))
         0, 1, 2, 3: return {$urandom, $urandom};
         4:          return POS_ZERO;
         5:          return NEG_ZERO;
         6:          return POS_ONE;
         7:          return NEG_ONE;
         8:          return POS_INF;
         9:          return NEG_INF;
         10:         return MIN_SUBNORM;
         default:    return NEG_SUBNORM;
      endcase
   endfunction

   // a repeated vertex may come back with its zeros of either sign
   function automatic coord_type swap_zero_signs(input coord_type v);
      if (v.x_bits[COORD_W-2:0] == '0) v.x_bits[COORD_W-1] = 1'($urandom_range(0, 1));
      if (v.y_bits[COORD_W-2:0] == '0) v.y_bits[COORD_W-1] = 1'($urandom_range(0, 1));
      if (v.z_bits[COORD_W-2:0] == '0) v.z_bits[COORD_W-1] = 1'($urandom_range(0, 1));
      return v;
   endfunction

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_vertex(input coord_type v, input logic fresh);
      req_type beat;
      beat.x_bits   = v.x_bits;
      beat.y_bits   = v.y_bits;
      beat.z_bits   = v.z_bits;
      beat.new_mesh = fresh;
      // random idle cycles ahead of the beat
      while (!calm && ($urandom_range(0, 99) < 12)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      coord_type   mesh_verts [$];
      coord_type   fill_verts [$];
      coord_type   v;
      logic        fresh;
      int          mesh_size;
      int          sent;
      int          k;
      int          pick;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // zeros of both signs collapse to one entry
      send_vertex(make_vertex(POS_ZERO, POS_ZERO, POS_ZERO), 1'b1);
      send_vertex(make_vertex(NEG_ZERO, NEG_ZERO, NEG_ZERO), 1'b0);
      send_vertex(make_vertex(NEG_ZERO, POS_ZERO, NEG_ZERO), 1'b0);
      // all ones is a NaN pattern, matches only itself
      send_vertex(make_vertex(ALL_ONES, ALL_ONES, ALL_ONES), 1'b0);
      send_vertex(make_vertex(ALL_ONES, ALL_ONES, ALL_ONES), 1'b0);
      send_vertex(make_vertex(QUIET_NAN, ALL_ONES, ALL_ONES), 1'b0);
      // extremes of the finite range and infinities
      send_vertex(make_vertex(MAX_FINITE, NEG_INF, POS_INF), 1'b0);
      // tiny values are not zero
      send_vertex(make_vertex(MIN_SUBNORM, POS_ZERO, POS_ZERO), 1'b0);
      send_vertex(make_vertex(NEG_SUBNORM, POS_ZERO, POS_ZERO), 1'b0);
      // differ in one coordinate only
      send_vertex(make_vertex(POS_ZERO, POS_ZERO, POS_ONE), 1'b0);
      send_vertex(make_vertex(POS_ONE, POS_ZERO, POS_ZERO), 1'b0);
      send_vertex(make_vertex(POS_ZERO, NEG_ONE, NEG_ZERO), 1'b0);
      send_vertex(make_vertex(MAX_FINITE, NEG_INF, POS_INF), 1'b0);
      send_vertex(make_vertex(NEG_SUBNORM, NEG_ZERO, POS_ZERO), 1'b0);
      // new mesh restarts numbering, even for a vertex stored before
      send_vertex(make_vertex(MAX_FINITE, NEG_INF, POS_INF), 1'b1);
      send_vertex(make_vertex(POS_ZERO, POS_ZERO, POS_ZERO), 1'b0);
      send_vertex(make_vertex(NEG_ZERO, NEG_ZERO, NEG_ZERO), 1'b1);
      send_vertex(make_vertex(NEG_ZERO, NEG_ZERO, NEG_ZERO), 1'b1);
      send_vertex(make_vertex(ALL_ONES, ALL_ONES, ALL_ONES), 1'b0);

      // --- small meshes with plenty of repeats ---
      sent = 0;
      while (sent < SMALL_MESH_ITEMS) begin
         mesh_size = $urandom_range(1, 48);
         for (k = 0; k < mesh_size; k++) begin
            if (mesh_verts.size() != 0 && $urandom_range(0, 99) < 45)
               v = swap_zero_signs(mesh_verts[$urandom_range(0, mesh_verts.size() - 1)]);
            else
               v = make_vertex(pick_coord(), pick_coord(), pick_coord());
            // most meshes start clean, a few keep growing, rare clears mid-stream
            fresh = (k == 0) ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 2);
            if (fresh) mesh_verts.delete();
            send_vertex(v, fresh);
            mesh_verts.insert(mesh_verts.size(), v);
            sent++;
         end
      end

      // --- fill the table to the brim, first part without any idling ---
      for (k = 0; k < MAX_VERTS; k++) begin
         calm <= (k < CALM_ITEMS);
         // low word of x holds k so every vertex is distinct
         v = make_vertex({$urandom, 32'(k)}, {$urandom, $urandom}, pick_coord());
         send_vertex(v, k == 0);
         fill_verts.insert(fill_verts.size(), v);
      end
      calm <= 1'b0;

      // --- full table: hits anywhere, including both ends, and overflows ---
      for (k = 0; k < PROBE_ITEMS; k++) begin
         pick = $urandom_range(0, 99);
         if (k == 0)
            v = fill_verts[0];
         else if (k == 1)
            v = fill_verts[MAX_VERTS - 1];
         else if (pick < 50)
            v = swap_zero_signs(fill_verts[$urandom_range(0, MAX_VERTS - 1)]);
         else
            v = make_vertex(pick_coord(), pick_coord(), pick_coord());
         send_vertex(v, 1'b0);
      end

      // a new mesh after overflow starts over at index 0
      send_vertex(fill_verts[$urandom_range(0, MAX_VERTS - 1)], 1'b1);
      send_vertex(fill_verts[0], 1'b0);
      send_vertex(make_vertex(NEG_ZERO, POS_ZERO, NEG_ZERO), 1'b0);
      req_valid <= 1'b0;

      // drain, then give the unit time to show any extra beat
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
rtl/vdi_pkg.sv
rtl/vdi_cell.sv
rtl/vertex_dedup_indexer_unit.sv
sim/vdi_checker.sv
sim/tb_top.sv
